>>> rtl/core/swkcf_pkg.sv
// Shared types and constants for the sliding-window k-mer clump finder.
package swkcf_pkg;

    // Field widths
    localparam int BASE_W   = 2;
    localparam int KCODE_W  = 16;
    localparam int POS_W    = 32;
    localparam int KLEN_W   = 4;
    localparam int WLEN_W   = 11;
    localparam int CNT_W    = 11;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Reset values of the configuration registers
    localparam logic [KLEN_W-1:0] KLEN_RST = 4'd3;
    localparam logic [WLEN_W-1:0] WLEN_RST = 11'd500;
    localparam logic [CNT_W-1:0]  MOCC_RST = 11'd3;

    // Register map, word index = paddr[3:2]
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_KMER_LEN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIN_LEN  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_OCC  = 2'd2;

    // Queues
    localparam int CQ_DEPTH  = 2;
    localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH  = 2;
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);
    localparam int OUT_W     = KCODE_W + POS_W;

    // Back-end issue sequencer
    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } t_back_state;

endpackage

>>> rtl/core/swkcf_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
module swkcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-before-write on a shared address; data holds while no read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/swkcf_queue.sv
// Small synchronous FIFO between pipeline parts.
module swkcf_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data,
    output logic [CW-1:0]     o_count
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              push, pop;

    // a push into a full queue is ignored; the writer checks o_count first
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid & (r_count != CW'(DEPTH));
    assign pop          = o_pop_valid & i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign o_count      = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> rtl/core/swkcf_front.sv
// Front end: takes bases, builds k-mer codes, keeps the ring of recent k-mers.
module swkcf_front #(
    parameter int KMER_MAX   = 8,
    parameter int WINDOW_MAX = 1024,
    localparam int CB    = 2 * KMER_MAX,
    localparam int RA    = $clog2(WINDOW_MAX),
    localparam int RW    = RA + 2,
    localparam int CMD_W = 1 + 2 * CB + swkcf_pkg::POS_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_hold,
    input  logic [swkcf_pkg::KLEN_W-1:0]  i_kmer_len,
    input  logic [swkcf_pkg::WLEN_W-1:0]  i_win_len,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [swkcf_pkg::BASE_W-1:0]  i_base,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready,
    output logic [CMD_W-1:0]              o_cmd_data
);

    logic [CB-1:0]                    r_rolling, n_rolling;
    logic [swkcf_pkg::POS_W-1:0]      r_bases_seen;
    logic [RA-1:0]                    r_pos_mod;
    logic                             r_s1_valid, r_s1_dec;
    logic [CB-1:0]                    r_s1_code;
    logic [swkcf_pkg::POS_W-1:0]      r_s1_pos;

    logic [swkcf_pkg::KLEN_W-1:0]     k_eff, km1;
    logic [swkcf_pkg::WLEN_W-1:0]     len_eff;
    logic [CB-1:0]                    mask, code;
    logic                             has_inc, has_dec, accept;
    logic [RW-1:0]                    widx_sum, widx, ridx_sum, ridx;
    logic [CB-1:0]                    gone;

    always_comb begin
        if (i_kmer_len == '0) begin
            k_eff = swkcf_pkg::KLEN_W'(1);
        end else if (32'(i_kmer_len) > KMER_MAX) begin
            k_eff = swkcf_pkg::KLEN_W'(KMER_MAX);
        end else begin
            k_eff = i_kmer_len;
        end
    end

    assign km1     = k_eff - 1'b1;
    assign len_eff = (32'(i_win_len) > WINDOW_MAX) ? swkcf_pkg::WLEN_W'(WINDOW_MAX) : i_win_len;

    always_comb begin
        for (int j = 0; j < CB; j++) begin
            mask[j] = (j < 2 * int'(k_eff));
        end
    end

    assign n_rolling = CB'({r_rolling, i_base});
    assign code      = n_rolling & mask;

    // k-mer finished once k bases are in and the window can hold it
    assign has_inc = (r_bases_seen >= 32'(km1)) && (len_eff >= swkcf_pkg::WLEN_W'(k_eff));
    // a k-mer leaves the window once pos reaches the window length
    assign has_dec = (r_bases_seen >= 32'(len_eff));

    // ring slots from pos mod window size: one add and a conditional subtract
    assign widx_sum = RW'(r_pos_mod) + RW'(WINDOW_MAX) - RW'(km1);
    assign widx     = (widx_sum >= RW'(WINDOW_MAX)) ? widx_sum - RW'(WINDOW_MAX) : widx_sum;
    assign ridx_sum = RW'(r_pos_mod) + RW'(WINDOW_MAX) - RW'(len_eff);
    assign ridx     = (ridx_sum >= RW'(WINDOW_MAX)) ? ridx_sum - RW'(WINDOW_MAX) : ridx_sum;

    assign o_s_tready = !i_hold && (!r_s1_valid || i_cmd_ready);
    assign accept     = i_s_tvalid & o_s_tready;

    swkcf_ram #(
        .WIDTH (CB),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept & has_inc),
        .i_waddr (widx[RA-1:0]),
        .i_wdata (code),
        .i_re    (accept & has_inc & has_dec),
        .i_raddr (ridx[RA-1:0]),
        .o_rdata (gone)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rolling    <= '0;
            r_bases_seen <= '0;
            r_pos_mod    <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_rolling  <= n_rolling;
                r_s1_valid <= has_inc;
                if (r_bases_seen != swkcf_pkg::POS_MAX) begin
                    r_bases_seen <= r_bases_seen + 1'b1;
                    r_pos_mod    <= (r_pos_mod == RA'(WINDOW_MAX - 1)) ? '0 : r_pos_mod + 1'b1;
                end
            end else if (i_cmd_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_dec  <= has_dec;
            r_s1_code <= code;
            r_s1_pos  <= r_bases_seen;
        end
    end

    // gone is only meaningful when r_s1_dec is set
    assign o_cmd_valid = r_s1_valid;
    assign o_cmd_data  = {r_s1_dec, gone, r_s1_code, r_s1_pos};

endmodule

>>> rtl/core/swkcf_back.sv
// Back end: count memory read-modify-write, clump detection, clearing pass.
module swkcf_back #(
    parameter int KMER_MAX = 8,
    localparam int CB    = 2 * KMER_MAX,
    localparam int CMD_W = 1 + 2 * CB + swkcf_pkg::POS_W,
    localparam int MW    = swkcf_pkg::CNT_W + 1,
    localparam int CW    = swkcf_pkg::OQ_CNT_W + 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [swkcf_pkg::CNT_W-1:0]     i_min_occ,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_ready,
    input  logic [CMD_W-1:0]                i_cmd_data,
    output logic                            o_out_valid,
    output logic [swkcf_pkg::OUT_W-1:0]     o_out_data,
    input  logic [swkcf_pkg::OQ_CNT_W-1:0]  i_out_count,
    input  logic                            i_out_pop,
    output logic                            o_clr_busy
);

    swkcf_pkg::t_back_state          r_state, n_state;
    logic                            r_clr_busy;
    logic [CB-1:0]                   r_clr_addr;
    logic                            r_s2_valid, r_s2_dec;
    logic [CB-1:0]                   r_s2_addr;
    logic [swkcf_pkg::POS_W-1:0]     r_s2_pos;
    logic                            r_fwd_valid;
    logic [CB-1:0]                   r_fwd_addr;
    logic [MW-1:0]                   r_fwd_data;

    logic                            cmd_dec;
    logic [CB-1:0]                   cmd_gone, cmd_code;
    logic [swkcf_pkg::POS_W-1:0]     cmd_pos;
    logic                            room, issue, issue_dec;
    logic [CB-1:0]                   issue_addr;
    logic [CW-1:0]                   need;

    logic [MW-1:0]                   rdata, cur, upd;
    logic [swkcf_pkg::CNT_W-1:0]     cnt, n_cnt;
    logic                            mark, hit;
    logic                            we;
    logic [CB-1:0]                   waddr;
    logic [MW-1:0]                   wdata;

    assign cmd_dec  = i_cmd_data[CMD_W-1];
    assign cmd_gone = i_cmd_data[swkcf_pkg::POS_W+2*CB-1 -: CB];
    assign cmd_code = i_cmd_data[swkcf_pkg::POS_W+CB-1 -: CB];
    assign cmd_pos  = i_cmd_data[swkcf_pkg::POS_W-1:0];

    // an increment may emit; keep a free output slot for each one in flight
    assign need = CW'(i_out_count) + CW'(r_s2_valid & !r_s2_dec);
    assign room = need < (CW'(swkcf_pkg::OQ_DEPTH) + CW'(i_out_pop));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swkcf_pkg::BK_FIRST: begin
                if (i_cmd_valid && !r_clr_busy && cmd_dec) begin
                    n_state = swkcf_pkg::BK_SECOND;
                end
            end
            swkcf_pkg::BK_SECOND: begin
                if (room) begin
                    n_state = swkcf_pkg::BK_FIRST;
                end
            end
            default: n_state = swkcf_pkg::BK_FIRST;
        endcase
    end

    // issue: leaving k-mer first, then the entering one
    always_comb begin
        issue       = 1'b0;
        issue_dec   = 1'b0;
        issue_addr  = cmd_code;
        o_cmd_ready = 1'b0;
        unique case (r_state)
            swkcf_pkg::BK_FIRST: begin
                if (i_cmd_valid && !r_clr_busy) begin
                    if (cmd_dec) begin
                        issue      = 1'b1;
                        issue_dec  = 1'b1;
                        issue_addr = cmd_gone;
                    end else if (room) begin
                        issue       = 1'b1;
                        o_cmd_ready = 1'b1;
                    end
                end
            end
            swkcf_pkg::BK_SECOND: begin
                if (room) begin
                    issue       = 1'b1;
                    o_cmd_ready = 1'b1;
                end
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    // stage 2: modify; forward the write of the previous cycle
    assign cur  = (r_fwd_valid && r_fwd_addr == r_s2_addr) ? r_fwd_data : rdata;
    assign mark = cur[MW-1];
    assign cnt  = cur[swkcf_pkg::CNT_W-1:0];

    always_comb begin
        if (r_s2_dec) begin
            n_cnt = (cnt != '0) ? cnt - 1'b1 : cnt;
            hit   = 1'b0;
        end else begin
            n_cnt = (cnt != swkcf_pkg::CNT_MAX) ? cnt + 1'b1 : cnt;
            hit   = (n_cnt >= i_min_occ) && !mark;
        end
    end

    assign upd   = {mark | hit, n_cnt};
    assign we    = r_clr_busy | r_s2_valid;
    assign waddr = r_clr_busy ? r_clr_addr : r_s2_addr;
    assign wdata = r_clr_busy ? '0 : upd;

    swkcf_ram #(
        .WIDTH (MW),
        .DEPTH (2 ** CB)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (issue_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swkcf_pkg::BK_FIRST;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s2_valid  <= issue;
            r_fwd_valid <= r_s2_valid;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2_dec  <= issue_dec;
            r_s2_addr <= issue_addr;
            r_s2_pos  <= cmd_pos;
        end
        r_fwd_addr <= r_s2_addr;
        r_fwd_data <= upd;
    end

    assign o_out_valid = r_s2_valid & hit;
    assign o_out_data  = {r_s2_pos, swkcf_pkg::KCODE_W'(r_s2_addr)};
    assign o_clr_busy  = r_clr_busy;

endmodule

>>> rtl/core/sliding_window_kmer_clump_finder_unit.sv
// Top level of the sliding-window k-mer clump finder.
//
// Bases stream in on s_tdata[1:0] (0 A, 1 C, 2 G, 3 T). For every finished
// k-mer the count of the k-mer leaving the window is lowered, the new one's
// count raised, and a k-mer whose count first reaches min_occurrences is
// reported once on the master side with its end position. Once the window is
// full, each base issues one decrement and then one increment to the count
// memory (one access each per cycle); before that, only an increment. A new
// base can be taken while earlier ones are still in flight; a report passes
// the front stage, the command queue, the back end and the output queue.
// After reset the count memory is swept to zero, one entry per cycle, over all
// 2**(2*KMER_MAX) entries (65536 at the default); s_tready stays low meanwhile,
// register writes are taken as usual. Registers are to be written only while
// no transaction is in progress. Counts saturate at 2047 and the position
// counter stops at its all-ones value.
module sliding_window_kmer_clump_finder_unit #(
    parameter int KMER_MAX   = 8,
    parameter int WINDOW_MAX = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [1:0] base, [7:2] zero
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] kmer_code, [47:16] end_position
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CB    = 2 * KMER_MAX;
    localparam int CMD_W = 1 + 2 * CB + swkcf_pkg::POS_W;

    // configuration registers
    logic [swkcf_pkg::KLEN_W-1:0]    r_kmer_len;
    logic [swkcf_pkg::WLEN_W-1:0]    r_win_len;
    logic [swkcf_pkg::CNT_W-1:0]     r_min_occ;
    logic                            cfg_wr;
    logic [swkcf_pkg::REG_IDX_W-1:0] reg_idx;

    // front to back
    logic                            cmd_in_valid, cmd_in_ready;
    logic [CMD_W-1:0]                cmd_in_data;
    logic                            cmd_out_valid, cmd_out_ready;
    logic [CMD_W-1:0]                cmd_out_data;
    logic [swkcf_pkg::CQ_CNT_W-1:0]  cmd_count;
    logic                            clr_busy;

    // back to output queue
    logic                            res_valid;
    logic [swkcf_pkg::OUT_W-1:0]     res_data;
    logic [swkcf_pkg::OQ_CNT_W-1:0]  out_count;
    logic                            out_pop;

    // ---------------------------------------------------------------
    // Register port: always ready, written on the access phase
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= swkcf_pkg::KLEN_RST;
            r_win_len  <= swkcf_pkg::WLEN_RST;
            r_min_occ  <= swkcf_pkg::MOCC_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                swkcf_pkg::REG_KMER_LEN: r_kmer_len <= pwdata[swkcf_pkg::KLEN_W-1:0];
                swkcf_pkg::REG_WIN_LEN:  r_win_len  <= pwdata[swkcf_pkg::WLEN_W-1:0];
                swkcf_pkg::REG_MIN_OCC:  r_min_occ  <= pwdata[swkcf_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            swkcf_pkg::REG_KMER_LEN: prdata = 32'(r_kmer_len);
            swkcf_pkg::REG_WIN_LEN:  prdata = 32'(r_win_len);
            swkcf_pkg::REG_MIN_OCC:  prdata = 32'(r_min_occ);
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front: rolling code, position, ring of recent k-mers
    // ---------------------------------------------------------------
    swkcf_front #(
        .KMER_MAX   (KMER_MAX),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clr_busy),
        .i_kmer_len  (r_kmer_len),
        .i_win_len   (r_win_len),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_base      (s_tdata[swkcf_pkg::BASE_W-1:0]),
        .o_cmd_valid (cmd_in_valid),
        .i_cmd_ready (cmd_in_ready),
        .o_cmd_data  (cmd_in_data)
    );

    // short queue so front and back stall independently
    assign cmd_in_ready = (cmd_count != swkcf_pkg::CQ_CNT_W'(swkcf_pkg::CQ_DEPTH));

    swkcf_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (swkcf_pkg::CQ_DEPTH)
    ) u_cmd_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (cmd_in_valid),
        .i_push_data  (cmd_in_data),
        .o_pop_valid  (cmd_out_valid),
        .i_pop_ready  (cmd_out_ready),
        .o_pop_data   (cmd_out_data),
        .o_count      (cmd_count)
    );

    // ---------------------------------------------------------------
    // Back: count memory updates and clump detection
    // ---------------------------------------------------------------
    swkcf_back #(
        .KMER_MAX (KMER_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_occ   (r_min_occ),
        .i_cmd_valid (cmd_out_valid),
        .o_cmd_ready (cmd_out_ready),
        .i_cmd_data  (cmd_out_data),
        .o_out_valid (res_valid),
        .o_out_data  (res_data),
        .i_out_count (out_count),
        .i_out_pop   (out_pop),
        .o_clr_busy  (clr_busy)
    );

    // result buffer; the back end only pushes when a slot is reserved
    assign out_pop = m_tvalid & m_tready;

    swkcf_queue #(
        .DATA_W (swkcf_pkg::OUT_W),
        .DEPTH  (swkcf_pkg::OQ_DEPTH)
    ) u_out_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (res_valid),
        .i_push_data  (res_data),
        .o_pop_valid  (m_tvalid),
        .i_pop_ready  (m_tready),
        .o_pop_data   (m_tdata),
        .o_count      (out_count)
    );

endmodule

>>> test/sliding_window_kmer_clump_finder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window k-mer clump finder unit.
module sliding_window_kmer_clump_finder_unit_tb;

    localparam int KMER_LIMIT   = 8;
    localparam int WINDOW_LIMIT = 1024;
    localparam int RANDOM_BASES = 1700;
    localparam int SETTLE       = 16;    // margin for the pipeline to settle
    localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles

    // Nucleotide codes as carried in s_tdata[1:0]
    typedef enum logic [swkcf_pkg::BASE_W-1:0] {
        NT_A = 2'd0,
        NT_C = 2'd1,
        NT_G = 2'd2,
        NT_T = 2'd3
    } t_nucleotide;

    // Reference behaviour: counts per k-mer over the window, first-hit marks and
    // the queue of clump reports still owed by the block.
    class t_clump_scoreboard;
        typedef struct packed {
            logic [swkcf_pkg::KCODE_W-1:0] code;
            logic [swkcf_pkg::POS_W-1:0]   pos;
        } t_clump_hit;

        logic [swkcf_pkg::KLEN_W-1:0]  kmer_len;
        logic [swkcf_pkg::WLEN_W-1:0]  win_len;
        logic [swkcf_pkg::CNT_W-1:0]   min_occ;
        logic [swkcf_pkg::KCODE_W-1:0] roll;
        logic [swkcf_pkg::KCODE_W-1:0] ring [WINDOW_LIMIT];
        bit                            ring_written [WINDOW_LIMIT];
        logic [swkcf_pkg::CNT_W-1:0]   counts [1 << (2 * KMER_LIMIT)];
        bit                            marks [1 << (2 * KMER_LIMIT)];
        logic [swkcf_pkg::POS_W-1:0]   pos_count;
        t_clump_hit                    pending_clumps [$];
        int                            mismatches;
        int                            clumps_checked;

        function new();
            kmer_len  = swkcf_pkg::KLEN_RST;
            win_len   = swkcf_pkg::WLEN_RST;
            min_occ   = swkcf_pkg::MOCC_RST;
            roll      = '0;
            pos_count = '0;
            foreach (ring[i]) begin
                ring[i]         = '0;
                ring_written[i] = 1'b0;
            end
            foreach (counts[i]) begin
                counts[i] = '0;
                marks[i]  = 1'b0;
            end
            mismatches     = 0;
            clumps_checked = 0;
        endfunction

        function void flag(input string msg);
            if (mismatches < 10)
                $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endfunction

        function void set_reg(input logic [swkcf_pkg::REG_IDX_W-1:0] idx,
                              input logic [31:0] value);
            case (idx)
                swkcf_pkg::REG_KMER_LEN: kmer_len = value[swkcf_pkg::KLEN_W-1:0];
                swkcf_pkg::REG_WIN_LEN:  win_len  = value[swkcf_pkg::WLEN_W-1:0];
                swkcf_pkg::REG_MIN_OCC:  min_occ  = value[swkcf_pkg::CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(input logic [swkcf_pkg::REG_IDX_W-1:0] idx);
            case (idx)
                swkcf_pkg::REG_KMER_LEN: return 32'(kmer_len);
                swkcf_pkg::REG_WIN_LEN:  return 32'(win_len);
                swkcf_pkg::REG_MIN_OCC:  return 32'(min_occ);
                default:                 return '0;
            endcase
        endfunction

        static function int unsigned eff_k(input int unsigned k_raw);
            if (k_raw < 1) return 1;
            if (k_raw > KMER_LIMIT) return KMER_LIMIT;
            return k_raw;
        endfunction

        static function int unsigned eff_len(input int unsigned len_raw);
            return (len_raw > WINDOW_LIMIT) ? WINDOW_LIMIT : len_raw;
        endfunction

        // Would a stream under this setting read a ring slot never written?
        // The slot leaving at position p is p - len; only slots from before the
        // change of setting are at risk.
        function bit ring_reads_ok(input int unsigned k_raw, input int unsigned len_raw);
            int unsigned k, len, p;
            k   = eff_k(k_raw);
            len = eff_len(len_raw);
            if (len < k)
                return 1'b1;
            for (p = pos_count; p < pos_count + len - k + 1; p++)
                if (p >= len && !ring_written[(p - len) % WINDOW_LIMIT])
                    return 1'b0;
            return 1'b1;
        endfunction

        // One accepted base: slide the window, update counts, note any new clump
        function void count_base(input logic [swkcf_pkg::BASE_W-1:0] b);
            int unsigned                   k, len, span, pos, idx;
            logic [swkcf_pkg::KCODE_W-1:0] mask, code, gone;
            t_clump_hit                    hit;
            k    = eff_k(kmer_len);
            mask = swkcf_pkg::KCODE_W'((32'd1 << (2 * k)) - 1);
            pos  = pos_count;
            roll = {roll[swkcf_pkg::KCODE_W-3:0], b};
            if (pos_count != swkcf_pkg::POS_MAX)
                pos_count++;
            if (pos < k - 1)
                return;
            len = eff_len(win_len);
            if (len < k)
                return;
            span = len - k + 1;
            idx  = pos - (k - 1);
            code = roll & mask;
            if (idx >= span) begin
                gone = ring[(idx - span) % WINDOW_LIMIT];
                if (counts[gone] != 0)
                    counts[gone]--;
            end
            ring[idx % WINDOW_LIMIT]         = code;
            ring_written[idx % WINDOW_LIMIT] = 1'b1;
            if (counts[code] != swkcf_pkg::CNT_MAX)
                counts[code]++;
            if (counts[code] >= min_occ && !marks[code]) begin
                marks[code] = 1'b1;
                hit.code    = code;
                hit.pos     = swkcf_pkg::POS_W'(pos);
                pending_clumps.insert(pending_clumps.size(), hit);
            end
        endfunction

        function void check_clump(
            input logic [swkcf_pkg::KCODE_W+swkcf_pkg::POS_W-1:0] data);
            t_clump_hit                    want;
            logic [swkcf_pkg::KCODE_W-1:0] got_code;
            logic [swkcf_pkg::POS_W-1:0]   got_pos;
            got_code = data[swkcf_pkg::KCODE_W-1:0];
            got_pos  = data[swkcf_pkg::KCODE_W +: swkcf_pkg::POS_W];
            clumps_checked++;
            if (pending_clumps.size() == 0) begin
                flag($sformatf("unexpected clump code %h pos %0d", got_code, got_pos));
                return;
            end
            want = pending_clumps.pop_front();
            if (got_code !== want.code)
                flag($sformatf("kmer_code exp %h got %h", want.code, got_code));
            if (got_pos !== want.pos)
                flag($sformatf("end_position exp %0d got %0d", want.pos, got_pos));
        endfunction

        function int owed();
            return pending_clumps.size();
        endfunction

        function void flush_leftovers();
            t_clump_hit left;
            while (pending_clumps.size() != 0) begin
                left = pending_clumps.pop_front();
                flag($sformatf("clump code %h pos %0d never reported", left.code, left.pos));
            end
        endfunction
    endclass

    // DUT signals, all inputs known from time zero
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [1:0] base, [7:2] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // [15:0] kmer_code, [47:16] end_position
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    t_clump_scoreboard sb;
    int bases_sent    = 0;
    int settings_used = 0;
    bit tx_quiet      = 1'b0;     // sender: stretch with no gaps
    bit rx_quiet      = 1'b0;     // receiver: stretch with no stalls
    bit rx_hold       = 1'b0;     // receiver: long hold-off in progress

    sliding_window_kmer_clump_finder_unit #(
        .KMER_MAX   (KMER_LIMIT),
        .WINDOW_MAX (WINDOW_LIMIT)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Generous ceiling: the post-reset count sweep alone covers 65536 entries
    initial begin
        #5_000_000;
        $display("sliding_window_kmer_clump_finder_unit verification failed");
        $finish;
    end

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 7));
    endfunction

    // ---------------------------------------------------------------
    // Register port: setup then access phase, read back after each write
    // ---------------------------------------------------------------
    task automatic reg_access(input logic [swkcf_pkg::REG_IDX_W-1:0] idx, input bit wr,
                              input logic [31:0] value, output logic [31:0] rd);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wr ? value : '0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_reg(input logic [swkcf_pkg::REG_IDX_W-1:0] idx);
        logic [31:0] rd;
        reg_access(idx, 1'b0, '0, rd);
        if (rd !== sb.reg_value(idx))
            sb.flag($sformatf("register %0d read exp %0d got %0d",
                              idx, sb.reg_value(idx), rd));
    endtask

    task automatic reg_write(input logic [swkcf_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        logic [31:0] rd;
        reg_access(idx, 1'b1, value, rd);
        sb.set_reg(idx, value);
        check_reg(idx);
    endtask

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // Offer one base after a random gap; returns at the accepting edge
    task automatic send_base(input logic [swkcf_pkg::BASE_W-1:0] b);
        int gap;
        if ($urandom_range(0, 23) == 0)
            tx_quiet = !tx_quiet;
        gap = draw_gap(tx_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(8 - swkcf_pkg::BASE_W){1'b0}}, b};
        do @(posedge i_clk); while (!s_tready);
        sb.count_base(b);
        bases_sent++;
    endtask

    task automatic send_string(input string seq);
        t_nucleotide nt;
        for (int i = 0; i < seq.len(); i++) begin
            case (seq[i])
                "C":     nt = NT_C;
                "G":     nt = NT_G;
                "T":     nt = NT_T;
                default: nt = NT_A;
            endcase
            send_base(nt);
        end
    endtask

    task automatic pause_offering();
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    // Sender quiet until every owed clump is out, then let the pipe settle
    task automatic wait_drained();
        while (sb.owed() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [swkcf_pkg::KLEN_W-1:0] k,
                                 input logic [swkcf_pkg::WLEN_W-1:0] wl,
                                 input logic [swkcf_pkg::CNT_W-1:0] mo);
        pause_offering();
        wait_drained();
        reg_write(swkcf_pkg::REG_KMER_LEN, 32'(k));
        reg_write(swkcf_pkg::REG_WIN_LEN, 32'(wl));
        reg_write(swkcf_pkg::REG_MIN_OCC, 32'(mo));
        settings_used++;
    endtask

    // Random setting, biased to short windows and low thresholds so clumps
    // come often; a setting that would touch an unwritten ring slot is refused.
    task automatic pick_setting(output logic [swkcf_pkg::KLEN_W-1:0] k,
                                output logic [swkcf_pkg::WLEN_W-1:0] wl,
                                output logic [swkcf_pkg::CNT_W-1:0] mo);
        bit ok;
        ok = 1'b0;
        for (int tries = 0; tries < 40 && !ok; tries++) begin
            if ($urandom_range(0, 9) == 0)
                k = swkcf_pkg::KLEN_W'($urandom_range(0, 15));
            else
                k = swkcf_pkg::KLEN_W'($urandom_range(2, KMER_LIMIT));
            case ($urandom_range(0, 9))
                0:       wl = swkcf_pkg::WLEN_W'($urandom_range(0, 2047));
                1:       wl = $urandom_range(0, 1) ? swkcf_pkg::WLEN_W'(1024)
                                                   : swkcf_pkg::WLEN_W'(2047);
                default: wl = swkcf_pkg::WLEN_W'(k) +
                              swkcf_pkg::WLEN_W'($urandom_range(0, 40));
            endcase
            case ($urandom_range(0, 9))
                0:       mo = swkcf_pkg::CNT_W'($urandom_range(0, 2047));
                1:       mo = $urandom_range(0, 1) ? swkcf_pkg::CNT_W'(1024)
                                                   : swkcf_pkg::CNT_W'(2047);
                default: mo = swkcf_pkg::CNT_W'($urandom_range(0, 4));
            endcase
            ok = sb.ring_reads_ok(k, wl);
        end
        // window shorter than k-mer never touches the ring
        if (!ok) begin
            k  = swkcf_pkg::KLEN_W'($urandom_range(2, KMER_LIMIT));
            wl = swkcf_pkg::WLEN_W'($urandom_range(1, k - 1));
            mo = swkcf_pkg::CNT_W'($urandom_range(0, 4));
        end
    endtask

    // Mostly repeated motifs with the odd point mutation, plus plain noise
    task automatic run_random(input int n);
        int                           sent_here, motif_len, reps;
        logic [swkcf_pkg::BASE_W-1:0] motif [12];
        logic [swkcf_pkg::BASE_W-1:0] b;
        sent_here = 0;
        while (sent_here < n) begin
            if ($urandom_range(0, 149) == 0) begin
                pause_offering();
                wait_drained();
            end
            if ($urandom_range(0, 9) < 7) begin
                motif_len = $urandom_range(1, 12);
                for (int i = 0; i < motif_len; i++)
                    motif[i] = swkcf_pkg::BASE_W'($urandom_range(0, 3));
                reps = $urandom_range(2, 6);
                for (int j = 0; j < reps; j++) begin
                    for (int i = 0; i < motif_len; i++) begin
                        b = motif[i];
                        if ($urandom_range(0, 24) == 0)
                            b = swkcf_pkg::BASE_W'($urandom_range(0, 3));
                        send_base(b);
                        sent_here++;
                    end
                end
            end else begin
                motif_len = $urandom_range(1, 20);
                for (int i = 0; i < motif_len; i++) begin
                    send_base(swkcf_pkg::BASE_W'($urandom_range(0, 3)));
                    sent_here++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls per transaction, long holds on request
    // ---------------------------------------------------------------
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                m_tready = 1'b0;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
            end
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                sb.check_clump(m_tdata);
                if ($urandom_range(0, 15) == 0)
                    rx_quiet = !rx_quiet;
                stall_left = draw_gap(rx_quiet);
            end
        end
    end

    // Long hold-offs while the sender keeps going: output queue fills and
    // s_tready has to drop
    initial begin : long_hold
        int marks_at [2];
        marks_at = '{400, 1100};
        foreach (marks_at[i]) begin
            wait (bases_sent >= marks_at[i]);
            @(negedge i_clk);
            rx_hold = 1'b1;
            repeat (LONG_HOLD) @(negedge i_clk);
            rx_hold = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        logic [swkcf_pkg::KLEN_W-1:0] k;
        logic [swkcf_pkg::WLEN_W-1:0] wl;
        logic [swkcf_pkg::CNT_W-1:0]  mo;
        int                           directed_bases;
        sb = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values of the register file
        check_reg(swkcf_pkg::REG_KMER_LEN);
        check_reg(swkcf_pkg::REG_WIN_LEN);
        check_reg(swkcf_pkg::REG_MIN_OCC);

        // k of zero taken as one, one-base window, threshold zero: every
        // single base reports at first sight (s_tready held low by the sweep)
        apply_setting(swkcf_pkg::KLEN_W'(0), swkcf_pkg::WLEN_W'(1), swkcf_pkg::CNT_W'(0));
        send_string("ATTCG");
        // reset-like setting, ACG repeated so it reaches three occurrences
        apply_setting(swkcf_pkg::KLEN_W'(3), swkcf_pkg::WLEN_W'(500), swkcf_pkg::CNT_W'(3));
        send_string("ACGACGACGACG");
        // k and window above their maxima, clamped to 8 and 1024
        apply_setting(swkcf_pkg::KLEN_W'(15), swkcf_pkg::WLEN_W'(2047),
                      swkcf_pkg::CNT_W'(1));
        send_string("TTTT");
        // window shorter than the k-mer, top threshold: nothing counted
        apply_setting(swkcf_pkg::KLEN_W'(KMER_LIMIT), swkcf_pkg::WLEN_W'(4),
                      swkcf_pkg::CNT_W'(2047));
        send_string("GCA");
        directed_bases = bases_sent;

        while (bases_sent < directed_bases + RANDOM_BASES) begin
            pick_setting(k, wl, mo);
            apply_setting(k, wl, mo);
            run_random($urandom_range(60, 250));
        end

        pause_offering();
        wait_drained();
        repeat (50) @(posedge i_clk);   // anything arriving now is spurious
        sb.flush_leftovers();

        $display("Covered %0d bases under %0d register settings; %0d clump reports checked.",
                 bases_sent, settings_used, sb.clumps_checked);
        if (sb.mismatches == 0) begin
            $display("sliding_window_kmer_clump_finder_unit verification clean");
        end else begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("sliding_window_kmer_clump_finder_unit verification failed");
        end
        $finish;
    end

endmodule
